// File: design/tta_pkg.sv
`default_nettype none
package tta_pkg;

   localparam int SLOTS  = 32;
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);

   // slot states
   localparam logic [1:0] ST_RUNNING  = 2'd0;
   localparam logic [1:0] ST_STOPPED  = 2'd1;
   localparam logic [1:0] ST_WAIT_ARB = 2'd2;

   // commands
   localparam logic [3:0] CMD_CREATE  = 4'd0;
   localparam logic [3:0] CMD_STOP    = 4'd1;
   localparam logic [3:0] CMD_SETPRIO = 4'd2;
   localparam logic [3:0] CMD_GETPRIO = 4'd3;
   localparam logic [3:0] CMD_SUSPEND = 4'd4;
   localparam logic [3:0] CMD_WAKE    = 4'd5;
   localparam logic [3:0] CMD_COMPACT = 4'd6;
   localparam logic [3:0] CMD_FIND    = 4'd7;
   localparam logic [3:0] CMD_ALIVE   = 4'd8;
   localparam logic [3:0] CMD_SELECT  = 4'd9;

   // status codes
   localparam logic [2:0] S_OK        = 3'd0;
   localparam logic [2:0] S_FULL      = 3'd1;
   localparam logic [2:0] S_NOT_FOUND = 3'd2;
   localparam logic [2:0] S_STOPPED   = 3'd3;
   localparam logic [2:0] S_BEYOND    = 3'd4;

   localparam logic [31:0] PSEUDO_HANDLE   = 32'hffff8000;
   localparam logic [7:0]  WAKE_PRIO_LIMIT = 8'h80;

   typedef struct packed {
      logic [1:0]  state;
      logic [31:0] handle;
      logic [7:0]  prio;
      logic [31:0] arb;
      logic [31:0] addr;
   } entry_type;

   // ring control, broadcast from the head unit to every cell
   typedef struct packed {
      logic             shift;
      logic             ins_en;
      logic [IDX_W-1:0] tail_idx;
      entry_type        ins_entry;
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      entry_type        wr_entry;
   } ring_ctrl_type;

endpackage
`default_nettype wire

// File: design/thread_table_arbiter_wakeup.sv
`default_nettype none
// Thread table with arbiter wakeup. One command per transaction on the req_
// side, one result transaction on the rsp_ side. The entries live in a ring
// of cells; a command that has to look at entries rotates the ring once
// through a single head unit, one entry per cycle; create, an out-of-range
// index and an unknown command need no scan, and wake scans twice (find the
// best waiter, then update it).
// Compact drops stopped entries as they leave the head, keeping order.
// A new command is taken once the previous one has produced its result;
// the result register lets that result wait for rsp_tready.
module thread_table_arbiter_wakeup (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // command[3:0]
   input  wire logic [3:0]   req_tuser,
   // thread_handle[31:0], new_priority[39:32], slot_index[44:40],
   // arbiter_handle[76:45], wait_address[108:77], zero fill
   input  wire logic [111:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[2:0], found_index[7:3], found_priority[15:8], is_alive[16],
   // entry_count[22:17], zero fill
   output logic [23:0]       rsp_tdata
);

   localparam int IDX_W = tta_pkg::IDX_W;
   localparam int CNT_W = tta_pkg::CNT_W;

   // sequencer
   localparam logic [1:0] SQ_IDLE = 2'd0;
   localparam logic [1:0] SQ_PASS = 2'd1;
   localparam logic [1:0] SQ_DONE = 2'd2;

   tta_pkg::ring_ctrl_type ctrl;
   tta_pkg::entry_type     cell_q [tta_pkg::SLOTS];
   tta_pkg::entry_type     e;
   tta_pkg::entry_type     ins;

   // ring of cells; cell 0 is the head
   for (genvar k = 0; k < tta_pkg::SLOTS; k++) begin : g_cell
      if (k == tta_pkg::SLOTS - 1) begin : g_last
         tta_cell u_cell (
            .clock     (clock),
            .my_idx    (IDX_W'(k)),
            .ctrl      (ctrl),
            .nbr_entry (ctrl.ins_entry),
            .entry_q   (cell_q[k])
         );
      end else begin : g_mid
         tta_cell u_cell (
            .clock     (clock),
            .my_idx    (IDX_W'(k)),
            .ctrl      (ctrl),
            .nbr_entry (cell_q[k+1]),
            .entry_q   (cell_q[k])
         );
      end
   end

   logic [1:0]       sq_ff, sq_in;
   logic [3:0]       cmd_ff, cmd_in;
   logic [31:0]      handle_ff, handle_in;
   logic [7:0]       prio_ff, prio_in;
   logic [31:0]      arb_ff, arb_in;
   logic [31:0]      addr_ff, addr_in;
   logic [IDX_W-1:0] tgt_ff, tgt_in;
   logic             by_idx_ff, by_idx_in;
   logic [IDX_W-1:0] p_ff, p_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic             found_ff, found_in;
   logic             wake2_ff, wake2_in;
   logic [2:0]       status_ff, status_in;
   logic [IDX_W-1:0] fidx_ff, fidx_in;
   logic [7:0]       fprio_ff, fprio_in;
   logic             alive_ff, alive_in;
   logic [7:0]       best_ff, best_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [23:0]      rsp_data_ff, rsp_data_in;

   logic [4:0]       req_sidx;
   logic             sidx_beyond;
   logic             hit;
   logic             last;

   assign e           = cell_q[0];
   assign req_sidx    = req_tdata[44:40];
   assign sidx_beyond = 32'(req_sidx) >= 32'(count_ff);
   assign hit         = by_idx_ff ? (p_ff == tgt_ff) : (e.handle == handle_ff);
   assign last        = (CNT_W'(p_ff) == (count_ff - CNT_W'(1)));

   always_comb begin
      sq_in        = sq_ff;
      cmd_in       = cmd_ff;
      handle_in    = handle_ff;
      prio_in      = prio_ff;
      arb_in       = arb_ff;
      addr_in      = addr_ff;
      tgt_in       = tgt_ff;
      by_idx_in    = by_idx_ff;
      p_in         = p_ff;
      len_in       = len_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      found_in     = found_ff;
      wake2_in     = wake2_ff;
      status_in    = status_ff;
      fidx_in      = fidx_ff;
      fprio_in     = fprio_ff;
      alive_in     = alive_ff;
      best_in      = best_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ins          = e;

      ctrl           = '0;
      ctrl.tail_idx  = IDX_W'(len_ff - CNT_W'(1));

      unique case (sq_ff)
         SQ_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = req_tuser;
               handle_in = req_tdata[31:0];
               prio_in   = req_tdata[39:32];
               arb_in    = req_tdata[76:45];
               addr_in   = req_tdata[108:77];
               tgt_in    = IDX_W'(req_sidx);
               by_idx_in = 1'b1;
               p_in      = '0;
               len_in    = count_ff;
               found_in  = 1'b0;
               wake2_in  = 1'b0;
               status_in = tta_pkg::S_OK;
               fidx_in   = '0;
               fprio_in  = '0;
               alive_in  = 1'b0;
               best_in   = tta_pkg::WAKE_PRIO_LIMIT;
               sq_in     = SQ_DONE;
               case (req_tuser) inside
                  tta_pkg::CMD_CREATE: begin
                     if (32'(count_ff) >= 32'(tta_pkg::SLOTS)) begin
                        status_in = tta_pkg::S_FULL;
                     end else begin
                        ctrl.wr_en    = 1'b1;
                        ctrl.wr_idx   = IDX_W'(count_ff);
                        ctrl.wr_entry = '{state:  tta_pkg::ST_RUNNING,
                                          handle: req_tdata[31:0],
                                          prio:   req_tdata[39:32],
                                          arb:    32'd0,
                                          addr:   32'd0};
                        count_in      = count_ff + CNT_W'(1);
                        fidx_in       = IDX_W'(count_ff);
                     end
                  end
                  tta_pkg::CMD_STOP, tta_pkg::CMD_SUSPEND: begin
                     if (sidx_beyond) begin
                        status_in = tta_pkg::S_BEYOND;
                     end else begin
                        sq_in = SQ_PASS;
                     end
                  end
                  tta_pkg::CMD_SETPRIO, tta_pkg::CMD_GETPRIO, tta_pkg::CMD_FIND: begin
                     status_in = tta_pkg::S_NOT_FOUND;
                     if (req_tdata[31:0] == tta_pkg::PSEUDO_HANDLE) begin
                        // pseudo-handle: the current entry
                        tgt_in = cur_ff;
                        if (32'(cur_ff) >= 32'(count_ff)) begin
                           status_in = tta_pkg::S_BEYOND;
                        end else begin
                           sq_in = SQ_PASS;
                        end
                     end else begin
                        by_idx_in = 1'b0;
                        if (count_ff != '0) begin
                           sq_in = SQ_PASS;
                        end
                     end
                  end
                  tta_pkg::CMD_WAKE, tta_pkg::CMD_ALIVE: begin
                     status_in = tta_pkg::S_NOT_FOUND;
                     by_idx_in = 1'b0;
                     if (count_ff != '0) begin
                        sq_in = SQ_PASS;
                     end
                  end
                  tta_pkg::CMD_COMPACT: begin
                     if (count_ff != '0) begin
                        sq_in = SQ_PASS;
                     end
                  end
                  tta_pkg::CMD_SELECT: begin
                     if (sidx_beyond) begin
                        status_in = tta_pkg::S_BEYOND;
                     end else if (IDX_W'(req_sidx) != cur_ff) begin
                        sq_in = SQ_PASS;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         SQ_PASS: begin
            ctrl.shift  = 1'b1;
            ctrl.ins_en = 1'b1;
            p_in        = p_ff + IDX_W'(1);
            case (cmd_ff) inside
               tta_pkg::CMD_STOP: begin
                  if (hit) begin
                     ins.state = tta_pkg::ST_STOPPED;
                  end
               end
               tta_pkg::CMD_SUSPEND: begin
                  if (hit) begin
                     ins.state = tta_pkg::ST_WAIT_ARB;
                     ins.arb   = arb_ff;
                     ins.addr  = addr_ff;
                  end
               end
               tta_pkg::CMD_SETPRIO, tta_pkg::CMD_GETPRIO, tta_pkg::CMD_FIND: begin
                  // first match only
                  if (hit && !found_ff) begin
                     found_in  = 1'b1;
                     status_in = tta_pkg::S_OK;
                     fidx_in   = p_ff;
                     if (cmd_ff == tta_pkg::CMD_SETPRIO) begin
                        ins.prio = prio_ff;
                     end
                     if (cmd_ff == tta_pkg::CMD_GETPRIO) begin
                        fprio_in = e.prio;
                     end
                  end
               end
               tta_pkg::CMD_WAKE: begin
                  if (wake2_ff) begin
                     if (p_ff == fidx_ff) begin
                        ins.state = tta_pkg::ST_RUNNING;
                        ins.arb   = 32'd0;
                        ins.addr  = 32'd0;
                     end
                  end else if ((e.state == tta_pkg::ST_WAIT_ARB) && (e.arb == arb_ff) &&
                               (e.addr == addr_ff) && (e.prio <= best_ff)) begin
                     // <= keeps the later index on a tie
                     best_in  = e.prio;
                     fidx_in  = p_ff;
                     found_in = 1'b1;
                  end
               end
               tta_pkg::CMD_COMPACT: begin
                  if (e.state == tta_pkg::ST_STOPPED) begin
                     ctrl.ins_en = 1'b0;
                     len_in      = len_ff - CNT_W'(1);
                  end
               end
               tta_pkg::CMD_ALIVE: begin
                  // last match wins
                  if (e.handle == handle_ff) begin
                     found_in  = 1'b1;
                     status_in = tta_pkg::S_OK;
                     fidx_in   = p_ff;
                     alive_in  = (e.state != tta_pkg::ST_STOPPED);
                  end
               end
               tta_pkg::CMD_SELECT: begin
                  if (hit) begin
                     if (e.state == tta_pkg::ST_STOPPED) begin
                        status_in = tta_pkg::S_STOPPED;
                     end else begin
                        cur_in = tgt_ff;
                     end
                  end
               end
               default: begin
               end
            endcase
            if (last) begin
               p_in = '0;
               if ((cmd_ff == tta_pkg::CMD_WAKE) && !wake2_ff && found_in) begin
                  wake2_in  = 1'b1;
                  status_in = tta_pkg::S_OK;
               end else begin
                  sq_in = SQ_DONE;
                  if (cmd_ff == tta_pkg::CMD_COMPACT) begin
                     count_in = len_in;
                  end
               end
            end
         end

         SQ_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, 6'(count_ff), alive_ff, fprio_ff, 5'(fidx_ff),
                               status_ff};
               sq_in        = SQ_IDLE;
            end
         end

         default: begin
            sq_in = SQ_IDLE;
         end
      endcase

      ctrl.ins_entry = ins;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff        <= SQ_IDLE;
         count_ff     <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sq_ff        <= sq_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      handle_ff   <= handle_in;
      prio_ff     <= prio_in;
      arb_ff      <= arb_in;
      addr_ff     <= addr_in;
      tgt_ff      <= tgt_in;
      by_idx_ff   <= by_idx_in;
      p_ff        <= p_in;
      len_ff      <= len_in;
      found_ff    <= found_in;
      wake2_ff    <= wake2_in;
      status_ff   <= status_in;
      fidx_ff     <= fidx_in;
      fprio_ff    <= fprio_in;
      alive_ff    <= alive_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (sq_ff == SQ_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(tta_pkg::SLOTS))
      else $error("entry count above table size");

   a_pass_in_range: assert property (@(posedge clock) disable iff (reset)
      (sq_ff == SQ_PASS) |-> (CNT_W'(p_ff) < count_ff))
      else $error("scan position beyond entry count");

   a_compact_shrinks: assert property (@(posedge clock) disable iff (reset)
      (sq_ff == SQ_PASS) |=> (len_ff <= $past(len_ff)))
      else $error("ring length grew during a scan");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[2:0] <= tta_pkg::S_BEYOND))
      else $error("undefined status code");
`endif

endmodule
`default_nettype wire

// File: design/tta_cell.sv
`default_nettype none
module tta_cell (
   input  wire logic                          clock,
   input  wire logic [tta_pkg::IDX_W-1:0]     my_idx,
   input  wire tta_pkg::ring_ctrl_type        ctrl,
   input  wire tta_pkg::entry_type            nbr_entry,
   output tta_pkg::entry_type                 entry_q
);

   tta_pkg::entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.wr_en && (ctrl.wr_idx == my_idx)) begin
         entry_in = ctrl.wr_entry;
      end else if (ctrl.shift) begin
         // the tail cell takes the entry leaving the head
         if (ctrl.ins_en && (ctrl.tail_idx == my_idx)) begin
            entry_in = ctrl.ins_entry;
         end else begin
            entry_in = nbr_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule
`default_nettype wire
